/* src/bld_pkg.sv */
// Package for the bounded list deque engine: sizes, command and status
// codes, and the control bundle that the top level hands to every cell.
// No dependencies.
`default_nettype none

package bld_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // command codes
   typedef enum logic [2:0] {
      CMD_SEARCH       = 3'd0,
      CMD_PUSH_FRONT   = 3'd1,
      CMD_PUSH_BACK    = 3'd2,
      CMD_POP_FRONT    = 3'd3,
      CMD_POP_BACK     = 3'd4,
      CMD_REMOVE_VALUE = 3'd5
   } cmd_type;

   // status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // per-transfer control broadcast to the cell chain
   typedef struct packed {
      logic                  push_front; // every cell takes its left neighbor
      logic                  push_back;  // first free cell takes the operand
      logic                  pop_front;  // every cell takes its right neighbor
      logic                  pull_match; // cells at and after first match shift left
      logic [DATA_WIDTH-1:0] operand;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* src/bld_cell.sv */
// One slot of the list: holds a word, compares it with the operand and
// passes a first-match flag to the next slot. Depends on bld_pkg.
`default_nettype none

module bld_cell (
   input  wire logic                          clock,
   input  wire bld_pkg::cell_ctl_type         ctl,
   input  wire logic [bld_pkg::DATA_WIDTH-1:0] left_data,
   input  wire logic [bld_pkg::DATA_WIDTH-1:0] right_data,
   input  wire logic                          occ,
   input  wire logic                          occ_prev,
   input  wire logic                          seen_in,
   output logic                               seen_out,
   output logic [bld_pkg::DATA_WIDTH-1:0]      data_out
);
   import bld_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  match;

   // match only counts on a held entry
   assign match    = occ && (data_ff == ctl.operand);
   assign seen_out = seen_in | match;
   assign data_out = data_ff;

   // pick the word this slot holds next
   always_comb begin
      data_in = data_ff;
      if (ctl.push_front) begin
         data_in = left_data;
      end else if (ctl.push_back && occ_prev && !occ) begin
         data_in = ctl.operand;
      end else if (ctl.pop_front) begin
         data_in = right_data;
      end else if (ctl.pull_match && seen_out) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

/* src/bounded_list_deque_engine.sv */
// Top level of the bounded list deque engine: count register, command
// decode, the chain of bld_cell slots and the result registers.
// Depends on bld_pkg and bld_cell.
//
// Usage:
//   Input channel: drive req_cmd and req_operand_value and raise start;
//   a command transfers at each rising edge with start high and busy low.
//   busy is always low, so a command may be issued in every cycle.
//   Result channel: in the cycle after each command transfer, rsp_valid is
//   high for exactly one cycle with rsp_status, rsp_found,
//   rsp_removed_value and rsp_entry_count. The receiver cannot stall;
//   it must take the result in that cycle.
//   Throughput is 1 command per cycle: every slot compares its word
//   against the operand in parallel, a one-bit first-match flag ripples
//   down the slot chain, and each slot loads from its left or right
//   neighbor in the same cycle.
//   Reset (synchronous, active high) empties the list at once; slot
//   words are not cleared, only the count, and rsp_valid drops.
`default_nettype none

module bounded_list_deque_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_cmd,
   input  wire logic signed [bld_pkg::DATA_WIDTH-1:0] req_operand_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_found,
   output logic signed [bld_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   output logic [bld_pkg::COUNT_WIDTH-1:0]    rsp_entry_count
);
   import bld_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = COUNT_WIDTH'(DEPTH);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   valid_ff;
   status_type             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [DATA_WIDTH-1:0]  removed_ff, removed_in;

   cell_ctl_type           ctl;
   logic [DEPTH-1:0]       occ;
   logic [DEPTH:0]         seen;
   logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]  tail_data;
   logic                   full, empty, any_match;

   assign busy = 1'b0;

   // occupancy of each slot from the count
   for (genvar i = 0; i < DEPTH; i++) begin : g_occ
      assign occ[i] = count_ff > COUNT_WIDTH'(i);
   end

   // slot chain
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d, right_d;
      logic                  occ_p;
      if (i == 0) begin : g_first
         assign left_d = ctl.operand;
         assign occ_p  = 1'b1;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
         assign occ_p  = occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_inner
         assign right_d = cell_data[i+1];
      end
      bld_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_d),
         .right_data (right_d),
         .occ        (occ[i]),
         .occ_prev   (occ_p),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .data_out   (cell_data[i])
      );
   end

   assign full      = (count_ff == COUNT_FULL);
   assign empty     = (count_ff == '0);
   assign any_match = seen[DEPTH];

   // word in the last held slot
   always_comb begin
      tail_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (occ[i] && ((i == DEPTH - 1) || !occ[(i + 1) % DEPTH])) begin
            tail_data = tail_data | cell_data[i];
         end
      end
   end

   // command decode
   always_comb begin
      ctl         = '0;
      ctl.operand = req_operand_value;
      count_in    = count_ff;
      status_in   = ST_OK;
      found_in    = 1'b0;
      removed_in  = '0;
      if (start) begin
         case (req_cmd)
            CMD_SEARCH: begin
               found_in  = any_match;
               status_in = any_match ? ST_OK : ST_NOTFOUND;
            end
            CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.push_front = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.push_back = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctl.pop_front = 1'b1;
                  removed_in    = cell_data[0];
                  count_in      = count_ff - 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  removed_in = tail_data;
                  count_in   = count_ff - 1'b1;
               end
            end
            CMD_REMOVE_VALUE: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else if (any_match) begin
                  found_in       = 1'b1;
                  ctl.pull_match = 1'b1;
                  count_in       = count_ff - 1'b1;
               end else begin
                  status_in = ST_NOTFOUND;
               end
            end
            default: begin
               // unused codes: no operation
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= start;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      found_ff   <= found_in;
      removed_ff <= removed_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_found         = found_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_entry_count   = count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("entry count above depth");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_valid)
      else $error("command transfer without result");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (start && full && (req_cmd == CMD_PUSH_FRONT || req_cmd == CMD_PUSH_BACK))
      |=> (rsp_status == ST_FULL && rsp_entry_count == COUNT_FULL))
      else $error("insert into full list changed state");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("found with non-ok status");

endmodule

`default_nettype wire

/* dv/deque_checker.sv */
`timescale 1ns / 100ps
// Checker for the bounded list deque engine: tracks the list contents, predicts the
// result of each command transfer and compares it with the result channel.
// Depends on bld_pkg.

module deque_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 busy,
   input  wire logic [2:0]                           req_cmd,
   input  wire logic signed [bld_pkg::DATA_WIDTH-1:0] req_operand_value,
   input  wire logic                                 rsp_valid,
   input  wire logic [1:0]                           rsp_status,
   input  wire logic                                 rsp_found,
   input  wire logic signed [bld_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   input  wire logic [bld_pkg::COUNT_WIDTH-1:0]      rsp_entry_count,
   output int                                        mismatch_count,
   output int                                        results_pending
);
   import bld_pkg::*;

   typedef struct {
      status_type             status;
      logic                   found;
      logic [DATA_WIDTH-1:0]  removed;
      logic [COUNT_WIDTH-1:0] count;
   } list_outcome_type;

   // shadow list, front first in list_words[0 .. list_len-1]
   logic [DATA_WIDTH-1:0] list_words [DEPTH];
   int                    list_len;
   list_outcome_type      outcome_queue [$];

   // drop one entry and close the gap behind it
   task automatic close_gap_at(input int pos);
      for (int i = pos; i < list_len - 1; i++)
         list_words[i] = list_words[i + 1];
      list_len--;
   endtask

   // apply one command to the shadow list and work out its result
   task automatic apply_list_command(input logic [2:0] op,
                                     input logic [DATA_WIDTH-1:0] val,
                                     output list_outcome_type res);
      int hit;
      res.status  = ST_OK;
      res.found   = 1'b0;
      res.removed = '0;
      hit = -1;
      // first match nearest the front
      for (int i = 0; i < list_len; i++)
         if (hit < 0 && list_words[i] == val)
            hit = i;
      case (op)
         CMD_SEARCH: begin
            if (hit >= 0) res.found = 1'b1;
            else res.status = ST_NOTFOUND;
         end
         CMD_PUSH_FRONT: begin
            if (list_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = list_len; i > 0; i--)
                  list_words[i] = list_words[i - 1];
               list_words[0] = val;
               list_len++;
            end
         end
         CMD_PUSH_BACK: begin
            if (list_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               list_words[list_len] = val;
               list_len++;
            end
         end
         CMD_POP_FRONT: begin
            if (list_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.removed = list_words[0];
               close_gap_at(0);
            end
         end
         CMD_POP_BACK: begin
            if (list_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.removed = list_words[list_len - 1];
               list_len--;
            end
         end
         CMD_REMOVE_VALUE: begin
            if (list_len == 0) begin
               res.status = ST_EMPTY;
            end else if (hit >= 0) begin
               res.found = 1'b1;
               close_gap_at(hit);
            end else begin
               res.status = ST_NOTFOUND;
            end
         end
         default: ; // unused codes leave the list alone
      endcase
      res.count = COUNT_WIDTH'(list_len);
   endtask

   // compare the result of the previous transfer, then predict the new one
   always @(posedge clock) begin
      list_outcome_type want;
      if (reset) begin
         outcome_queue.delete();
         list_len       = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (outcome_queue.size() == 0) begin
               $display("%0t: result with none expected: status %0d count %0d",
                        $time, rsp_status, rsp_entry_count);
               mismatch_count++;
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_status != want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_found != want.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_removed_value != want.removed) begin
                  $display("%0t: removed_value expected %h actual %h",
                           $time, want.removed, rsp_removed_value);
                  mismatch_count++;
               end
               if (rsp_entry_count != want.count) begin
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.count, rsp_entry_count);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            apply_list_command(req_cmd, req_operand_value, want);
            outcome_queue.push_back(want);
         end
      end
      results_pending = outcome_queue.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the deque engine testbench: clock, reset, command stimulus and verdict.
// Depends on bld_pkg, bounded_list_deque_engine and deque_checker.

module tb_top;
   import bld_pkg::*;

   localparam int RANDOM_ITEMS   = 1650;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int POOL_SIZE      = 8;

   // codes outside the command set; the block treats them as no-ops
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} phase_mode_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [2:0]                    req_cmd;
   logic signed [DATA_WIDTH-1:0]  req_operand_value;
   logic                          rsp_valid;
   logic [1:0]                    rsp_status;
   logic                          rsp_found;
   logic signed [DATA_WIDTH-1:0]  rsp_removed_value;
   logic [COUNT_WIDTH-1:0]        rsp_entry_count;
   int                            mismatch_count;
   int                            results_pending;
   int                            quiet_cycles = 0;

   logic [DATA_WIDTH-1:0]         value_pool [POOL_SIZE];

   bounded_list_deque_engine dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

   deque_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count),
      .mismatch_count    (mismatch_count),
      .results_pending   (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // end the run if no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // drive one command at the falling edge and hold it until it transfers
   task automatic send_command(input logic [2:0] op, input logic [DATA_WIDTH-1:0] val);
      @(negedge clock);
      start             <= 1'b1;
      req_cmd           <= op;
      req_operand_value <= val;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [DATA_WIDTH-1:0] extreme_value();
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // mostly values from a small pool so searches and removals hit
   function automatic logic [DATA_WIDTH-1:0] pick_value(input int fresh_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < fresh_pct / 4) return extreme_value();
      if (r < fresh_pct) return $urandom;
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   initial begin
      phase_mode_type mode;
      int             phase_len;
      int             items_sent;
      int             burst_left;
      int             gap;
      int             r;
      logic [2:0]     op;

      reset             = 1'b1;
      start             = 1'b0;
      req_cmd           = CMD_SEARCH;
      req_operand_value = '0;
      foreach (value_pool[k]) value_pool[k] = $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, duplicates, misses, unused codes
      send_command(CMD_SEARCH, '0);
      send_command(CMD_POP_FRONT, 32'h1234_5678);
      send_command(CMD_POP_BACK, '1);
      send_command(CMD_REMOVE_VALUE, '0);
      send_command(CMD_PUSH_FRONT, 32'h8000_0000);
      send_command(CMD_PUSH_BACK, 32'h7FFF_FFFF);
      send_command(CMD_PUSH_FRONT, '0);
      send_command(CMD_PUSH_BACK, '1);
      send_command(CMD_PUSH_BACK, 32'h8000_0000);
      send_command(CMD_SEARCH, 32'h7FFF_FFFF);
      send_command(CMD_SEARCH, 32'h0000_0001);
      send_command(CMD_REMOVE_VALUE, 32'h8000_0000);
      send_command(CMD_REMOVE_VALUE, 32'h1234_5678);
      send_command(CMD_UNUSED_6, 32'h5A5A_5A5A);
      send_command(CMD_UNUSED_7, '1);
      send_command(CMD_POP_FRONT, '0);
      send_command(CMD_POP_BACK, '0);
      send_command(CMD_REMOVE_VALUE, '1);
      send_command(CMD_POP_FRONT, '0);
      send_command(CMD_PUSH_BACK, 32'h5555_5555);
      send_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA);

      // random phases that push the list toward full, toward empty, or neither
      items_sent = 0;
      burst_left = 0;
      while (items_sent < RANDOM_ITEMS) begin
         mode      = phase_mode_type'($urandom_range(0, 2));
         phase_len = $urandom_range(20, 60);
         repeat (phase_len) begin
            // sender pacing: bursts with gaps, some long unbroken stretches
            if (burst_left == 0) begin
               gap = $urandom_range(1, 6);
               @(negedge clock);
               start <= 1'b0;
               repeat (gap - 1) @(negedge clock);
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;

            r = $urandom_range(0, 99);
            case (mode)
               MODE_GROW:   r = (r < 70) ? 0 : (r < 80) ? 1 : (r < 88) ? 2 : 3;
               MODE_SHRINK: r = (r < 20) ? 0 : (r < 30) ? 1 : (r < 50) ? 2 : 3;
               default:     r = (r < 40) ? 0 : (r < 55) ? 1 : (r < 70) ? 2 : 3;
            endcase
            case (r)
               0: op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
               1: op = CMD_SEARCH;
               2: op = CMD_REMOVE_VALUE;
               default: op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            endcase

            // occasional noise with an unused code
            if ($urandom_range(0, 49) == 0) begin
               op = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
               send_command(op, $urandom);
            end else begin
               if (op == CMD_POP_FRONT || op == CMD_POP_BACK)
                  send_command(op, $urandom);
               else if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK)
                  send_command(op, pick_value(25));
               else
                  send_command(op, pick_value(15));
               items_sent++;
            end
         end
         // refresh part of the pool between phases
         value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
         value_pool[$urandom_range(0, POOL_SIZE - 1)] = extreme_value();
      end

      // drain: wait for every result, then idle before the verdict
      @(negedge clock);
      start <= 1'b0;
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

/* files.f */
src/bld_pkg.sv
src/bld_cell.sv
src/bounded_list_deque_engine.sv
dv/deque_checker.sv
dv/tb_top.sv
